/* rtl/core/vdat_pkg.sv */
// vdat_pkg: beat structs, codes and sizes shared by the VDAT plane decoder.
// No dependencies.
`timescale 1ns / 1ps

package vdat_pkg;

  // default size limits of the plane
  localparam int MaxColumnsDef = 32;
  localparam int MaxRowsDef    = 256;

  // results one token may cause, and a counter wide enough for that figure
  localparam int MaxResults = 32;
  localparam int ResW       = $clog2(MaxResults + 1);

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CFG_WORDS_PER_LINE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PLANE_HEIGHT   = 1'b1;
  localparam logic [5:0] WordsPerLineRst = 6'd20;
  localparam logic [8:0] PlaneHeightRst  = 9'd200;

  // token kinds
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_COUNT = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_SEGMENT  = 2'd0;
  localparam logic [1:0] ST_BAD_KIND = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  // decode phase: what the next token is expected to be
  typedef enum logic [2:0] {
    PH_CMD    = 3'd0,
    PH_LCOUNT = 3'd1,
    PH_RCOUNT = 3'd2,
    PH_RVALUE = 3'd3,
    PH_LWORDS = 3'd4
  } phase_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RUN  = 2'd2,
    S_TAIL = 2'd3
  } seq_t;

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [15:0] token;
    logic [1:0]  plane;
    logic        first_of_chunk;
    logic        last_of_chunk;
  } token_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  plane_index;
    logic [4:0]  column;
    logic [7:0]  start_row;
    logic [8:0]  run_length;
    logic [15:0] run_value;
    logic        last;
  } seg_beat_t;

endpackage

/* rtl/core/vdat_plane_decoder.sv */
// vdat_plane_decoder: VDAT bitplane decoder, tokens in, column segments out.
// Depends on vdat_pkg (beat structs, phase and sequencer enums, codes).
`timescale 1ns / 1ps

//  channel   | signals                                     | direction
//  ----------+---------------------------------------------+----------
//  token     | token_valid, token_ready, token_beat        | in
//  segment   | seg_valid, seg_ready, seg_beat              | out
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data   | in
//
// Each token is accepted in S_IDLE and decoded in S_EXEC; value and literal words then
// emit one column segment per cycle in S_RUN while the output slot is free, and then
// pass through S_TAIL; command bytes and count words go from decode to S_TAIL; a
// wrong-kind token with no truncation, or any token once the plane is full, returns to S_IDLE.
// Reset (rst, synchronous) restores the size registers and clears position.
// A held segment beat only stalls the sequencer when it must emit another.

module vdat_plane_decoder #(
  parameter int MAX_COLUMNS = vdat_pkg::MaxColumnsDef,
  parameter int MAX_ROWS    = vdat_pkg::MaxRowsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          token_valid,
  output logic                          token_ready,
  input  vdat_pkg::token_beat_t         token_beat,
  output logic                          seg_valid,
  input  logic                          seg_ready,
  output vdat_pkg::seg_beat_t           seg_beat,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vdat_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [vdat_pkg::CfgDataW-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int TW = $clog2(MAX_COLUMNS * MAX_ROWS + 1);

  // configuration registers
  logic [5:0] words_per_line;
  logic [8:0] plane_height;

  // decode state
  vdat_pkg::seq_t   state, state_next;
  vdat_pkg::phase_t phase, phase_next;
  logic [15:0] pending_count, pending_count_next;
  logic [4:0]  cur_column, cur_column_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [TW-1:0] words_done, words_done_next;
  logic [1:0]  cur_plane, cur_plane_next;
  logic [vdat_pkg::ResW-1:0] n_res, n_res_next;
  logic [15:0] run_count, run_count_next;
  logic [15:0] run_value, run_value_next;

  // latched token
  logic [1:0]  kind_r;
  logic [15:0] tok_r;
  logic        last_r;

  // emission into the output register
  logic                emit;
  vdat_pkg::seg_beat_t emit_beat;

  // effective sizes and plane total
  logic [CW-1:0] eff_cols;
  logic [RW-1:0] eff_rows;
  logic [TW-1:0] total;
  logic          full;

  always_comb begin
    if (words_per_line == 6'd0) begin
      eff_cols = CW'(1);
    end else if (32'(words_per_line) > 32'(MAX_COLUMNS)) begin
      eff_cols = CW'(MAX_COLUMNS);
    end else begin
      eff_cols = CW'(words_per_line);
    end
    if (plane_height == 9'd0) begin
      eff_rows = RW'(1);
    end else if (32'(plane_height) > 32'(MAX_ROWS)) begin
      eff_rows = RW'(MAX_ROWS);
    end else begin
      eff_rows = RW'(plane_height);
    end
  end

  assign total = TW'({{RW{1'b0}}, eff_cols} * {{CW{1'b0}}, eff_rows});
  assign full  = (words_done >= total);

  // shared segment unit: wrap, then minimum of room, count and words left
  logic [RW-1:0] row_w, row_after;
  logic [4:0]    col_w;
  logic [31:0]   room, left, len32;
  logic [RW-1:0] len;
  logic [TW-1:0] wd_after;
  logic [15:0]   cnt_after;

  always_comb begin
    if (cur_row >= eff_rows) begin
      row_w = '0;
      col_w = cur_column + 5'd1;
    end else begin
      row_w = cur_row;
      col_w = cur_column;
    end
    room  = 32'(eff_rows - row_w);
    left  = 32'(total - words_done);
    len32 = room;
    if (32'(run_count) < len32) begin
      len32 = 32'(run_count);
    end
    if (left < len32) begin
      len32 = left;
    end
    len       = RW'(len32);
    row_after = row_w + len;
    wd_after  = words_done + TW'(len);
    cnt_after = run_count - 16'(len);
  end

  // handshake helpers
  logic slot_free, kind_ok, run_go, res_room, res_room1, tok_acc;

  assign slot_free   = !seg_valid || seg_ready;
  assign token_ready = (state == vdat_pkg::S_IDLE);
  assign cfg_ready   = 1'b1;
  assign tok_acc     = token_valid && token_ready;
  assign res_room    = (n_res < vdat_pkg::ResW'(vdat_pkg::MaxResults));
  assign res_room1   = ((n_res + vdat_pkg::ResW'(1)) < vdat_pkg::ResW'(vdat_pkg::MaxResults));
  assign run_go      = (run_count != 16'd0) && !full && res_room;

  always_comb begin
    case (phase)
      vdat_pkg::PH_CMD:    kind_ok = (kind_r == vdat_pkg::KIND_CMD);
      vdat_pkg::PH_RCOUNT: kind_ok = (kind_r == vdat_pkg::KIND_COUNT);
      vdat_pkg::PH_LCOUNT,
      vdat_pkg::PH_RVALUE,
      vdat_pkg::PH_LWORDS: kind_ok = (kind_r == vdat_pkg::KIND_DATA);
      default:             kind_ok = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vdat_pkg::S_IDLE: begin
        if (token_valid) state_next = vdat_pkg::S_EXEC;
      end
      vdat_pkg::S_EXEC: begin
        if (full) begin
          state_next = vdat_pkg::S_IDLE;
        end else if (!kind_ok) begin
          if (slot_free) begin
            state_next = (last_r && phase != vdat_pkg::PH_CMD) ?
                         vdat_pkg::S_TAIL : vdat_pkg::S_IDLE;
          end
        end else if (phase == vdat_pkg::PH_RVALUE || phase == vdat_pkg::PH_LWORDS) begin
          state_next = vdat_pkg::S_RUN;
        end else begin
          state_next = vdat_pkg::S_TAIL;
        end
      end
      vdat_pkg::S_RUN: begin
        if (!run_go) state_next = vdat_pkg::S_TAIL;
      end
      vdat_pkg::S_TAIL: begin
        if (!full && last_r && phase != vdat_pkg::PH_CMD && res_room && !slot_free) begin
          state_next = vdat_pkg::S_TAIL;
        end else begin
          state_next = vdat_pkg::S_IDLE;
        end
      end
      default: state_next = vdat_pkg::S_IDLE;
    endcase
  end

  // datapath and emission
  always_comb begin
    logic [7:0] cmd_b;
    logic       more, trunc;
    cmd_b              = tok_r[7:0];
    more               = 1'b0;
    trunc              = 1'b0;
    phase_next         = phase;
    pending_count_next = pending_count;
    cur_column_next    = cur_column;
    cur_row_next       = cur_row;
    words_done_next    = words_done;
    cur_plane_next     = cur_plane;
    n_res_next         = n_res;
    run_count_next     = run_count;
    run_value_next     = run_value;
    emit               = 1'b0;
    emit_beat.status      = vdat_pkg::ST_SEGMENT;
    emit_beat.plane_index = cur_plane;
    emit_beat.column      = cur_column;
    emit_beat.start_row   = 8'(cur_row);
    emit_beat.run_length  = 9'd0;
    emit_beat.run_value   = 16'd0;
    emit_beat.last        = 1'b1;
    case (state)
      vdat_pkg::S_IDLE: begin
        n_res_next = '0;
        // start of a chunk clears position before the token is decoded
        if (tok_acc && token_beat.first_of_chunk) begin
          phase_next         = vdat_pkg::PH_CMD;
          pending_count_next = 16'd0;
          cur_column_next    = 5'd0;
          cur_row_next       = '0;
          words_done_next    = '0;
          cur_plane_next     = token_beat.plane;
        end
      end
      vdat_pkg::S_EXEC: begin
        if (full) begin
          // plane complete: token ignored
        end else if (!kind_ok) begin
          emit_beat.status = vdat_pkg::ST_BAD_KIND;
          emit_beat.last   = !(last_r && phase != vdat_pkg::PH_CMD);
          if (slot_free) begin
            emit       = 1'b1;
            n_res_next = n_res + vdat_pkg::ResW'(1);
          end
        end else begin
          case (phase)
            vdat_pkg::PH_CMD: begin
              if (cmd_b == 8'd0) begin
                phase_next = vdat_pkg::PH_LCOUNT;
              end else if (cmd_b == 8'd1) begin
                phase_next = vdat_pkg::PH_RCOUNT;
              end else if (cmd_b inside {[8'd128:8'd255]}) begin
                pending_count_next = {8'd0, 8'd0 - cmd_b};
                phase_next         = vdat_pkg::PH_LWORDS;
              end else begin
                pending_count_next = {8'd0, cmd_b};
                phase_next         = vdat_pkg::PH_RVALUE;
              end
            end
            vdat_pkg::PH_LCOUNT: begin
              pending_count_next = tok_r;
              phase_next = (tok_r != 16'd0) ? vdat_pkg::PH_LWORDS : vdat_pkg::PH_CMD;
            end
            vdat_pkg::PH_RCOUNT: begin
              pending_count_next = tok_r;
              phase_next         = vdat_pkg::PH_RVALUE;
            end
            vdat_pkg::PH_RVALUE: begin
              run_count_next     = pending_count;
              run_value_next     = tok_r;
              pending_count_next = 16'd0;
              phase_next         = vdat_pkg::PH_CMD;
            end
            vdat_pkg::PH_LWORDS: begin
              run_count_next = 16'd1;
              run_value_next = tok_r;
              if (pending_count > 16'd1) begin
                pending_count_next = pending_count - 16'd1;
              end else begin
                pending_count_next = 16'd0;
                phase_next         = vdat_pkg::PH_CMD;
              end
            end
            default: begin
              phase_next         = vdat_pkg::PH_CMD;
              pending_count_next = 16'd0;
            end
          endcase
        end
      end
      vdat_pkg::S_RUN: begin
        // one column segment per cycle while the output slot is free; last flag by lookahead
        more  = (cnt_after != 16'd0) && (wd_after < total) && res_room1;
        trunc = (wd_after < total) && last_r && (phase != vdat_pkg::PH_CMD) && res_room1;
        emit_beat.status     = vdat_pkg::ST_SEGMENT;
        emit_beat.column     = col_w;
        emit_beat.start_row  = 8'(row_w);
        emit_beat.run_length = 9'(len);
        emit_beat.run_value  = run_value;
        emit_beat.last       = !more && !trunc;
        if (run_go && slot_free) begin
          emit            = 1'b1;
          n_res_next      = n_res + vdat_pkg::ResW'(1);
          words_done_next = wd_after;
          run_count_next  = cnt_after;
          if (row_after >= eff_rows) begin
            cur_row_next    = '0;
            cur_column_next = col_w + 5'd1;
          end else begin
            cur_row_next    = row_after;
            cur_column_next = col_w;
          end
        end
      end
      vdat_pkg::S_TAIL: begin
        emit_beat.status = vdat_pkg::ST_TRUNC;
        if (full) begin
          phase_next         = vdat_pkg::PH_CMD;
          pending_count_next = 16'd0;
        end else if (last_r && phase != vdat_pkg::PH_CMD) begin
          if (!res_room) begin
            phase_next         = vdat_pkg::PH_CMD;
            pending_count_next = 16'd0;
          end else if (slot_free) begin
            emit               = 1'b1;
            n_res_next         = n_res + vdat_pkg::ResW'(1);
            phase_next         = vdat_pkg::PH_CMD;
            pending_count_next = 16'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= vdat_pkg::S_IDLE;
      phase          <= vdat_pkg::PH_CMD;
      pending_count  <= 16'd0;
      cur_column     <= 5'd0;
      cur_row        <= '0;
      words_done     <= '0;
      cur_plane      <= 2'd0;
      n_res          <= '0;
      run_count      <= 16'd0;
      seg_valid      <= 1'b0;
      words_per_line <= vdat_pkg::WordsPerLineRst;
      plane_height   <= vdat_pkg::PlaneHeightRst;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      pending_count <= pending_count_next;
      cur_column    <= cur_column_next;
      cur_row       <= cur_row_next;
      words_done    <= words_done_next;
      cur_plane     <= cur_plane_next;
      n_res         <= n_res_next;
      run_count     <= run_count_next;
      if (emit) begin
        seg_valid <= 1'b1;
      end else if (seg_ready) begin
        seg_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vdat_pkg::CFG_WORDS_PER_LINE: words_per_line <= cfg_data[5:0];
          vdat_pkg::CFG_PLANE_HEIGHT:   plane_height   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    run_value <= run_value_next;
    if (tok_acc) begin
      kind_r <= token_beat.token_kind;
      tok_r  <= token_beat.token;
      last_r <= token_beat.last_of_chunk;
    end
    if (emit) begin
      seg_beat <= emit_beat;
    end
  end

  // checks
  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    n_res <= vdat_pkg::ResW'(vdat_pkg::MaxResults))
    else $error("result count past limit");

  a_err_len: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && seg_beat.status != vdat_pkg::ST_SEGMENT) |-> (seg_beat.run_length == 9'd0))
    else $error("error beat with nonzero length");

  a_seg_len: assert property (@(posedge clk) disable iff (rst)
    (state == vdat_pkg::S_RUN && emit) |-> (len != '0))
    else $error("empty segment emitted");

  a_first_clear: assert property (@(posedge clk) disable iff (rst)
    (tok_acc && token_beat.first_of_chunk) |=> (words_done == '0 && cur_row == '0))
    else $error("chunk start did not clear position");

endmodule
